// ----- design/svwc_pkg.sv -----
// Package for the supply voltage window classifier: status codes, window table, classify helper.
package svwc_pkg;

   // Number of condition channels kept (1..8); channel c uses window row c mod 4.
   localparam int CHANNELS = 4;

   // Number of status fields on the result port.
   localparam int REPORTED = 4;

   localparam int VOLT_WIDTH   = 16;
   localparam int DECI_WIDTH   = 10;
   localparam int CSR_IDX_WIDTH = 1;

   // v / 100 == (v * DECI_RECIP) >> DECI_SHIFT for every 16-bit v.
   localparam logic [16:0] DECI_RECIP = 17'd83887;
   localparam int          DECI_SHIFT = 23;
   localparam int          PROD_WIDTH = VOLT_WIDTH + 17;

   localparam logic [VOLT_WIDTH-1:0] OFF_THRESHOLD_RESET = 16'd3000;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_SYSTEM_TYPE   = 1'b0,
      CSR_OFF_THRESHOLD = 1'b1
   } csr_index_type;

   typedef enum logic {
      SYSTEM_12V = 1'b0,
      SYSTEM_24V = 1'b1
   } system_type;

   typedef enum logic [1:0] {
      STATUS_INVALID = 2'd0,
      STATUS_LOW     = 2'd1,
      STATUS_NORMAL  = 2'd2,
      STATUS_HIGH    = 2'd3
   } status_type;

   typedef struct packed {
      logic [VOLT_WIDTH-1:0] normal_to_low;
      logic [VOLT_WIDTH-1:0] low_to_normal;
      logic [VOLT_WIDTH-1:0] normal_to_high;
      logic [VOLT_WIDTH-1:0] high_to_normal;
   } window_type;

   // Rows 0 and 2 share one window, rows 1 and 3 the other.
   function automatic window_type window_of(system_type sys, logic [1:0] row);
      window_type w;
      w = '0;
      case ({sys, row[0]})
         2'b00:   w = '{16'd8500,  16'd9000,  16'd16500, 16'd16000};
         2'b01:   w = '{16'd6000,  16'd6500,  16'd18000, 16'd17500};
         2'b10:   w = '{16'd17500, 16'd18000, 16'd32500, 16'd32000};
         2'b11:   w = '{16'd12000, 16'd12500, 16'd36000, 16'd35500};
         default: w = '0;
      endcase
      return w;
   endfunction

   // Hysteresis: previous status picks the lower and upper bounds.
   function automatic status_type classify(status_type prev, logic [VOLT_WIDTH-1:0] v,
                                           window_type w);
      logic [VOLT_WIDTH-1:0] lower;
      logic [VOLT_WIDTH-1:0] upper;
      status_type            s;
      case (prev)
         STATUS_NORMAL: begin
            lower = w.normal_to_low;
            upper = w.normal_to_high;
         end
         STATUS_HIGH: begin
            lower = w.normal_to_low;
            upper = w.high_to_normal;
         end
         default: begin
            lower = w.low_to_normal;
            upper = w.normal_to_high;
         end
      endcase
      if (v < lower) begin
         s = STATUS_LOW;
      end else if (v > upper) begin
         s = STATUS_HIGH;
      end else begin
         s = STATUS_NORMAL;
      end
      return s;
   endfunction

endpackage

// ----- design/supply_voltage_window_classifier.sv -----
// Top level of the supply voltage window classifier.
//
//  channel | ports                                   | dir | word
//  --------+-----------------------------------------+-----+------------------------------
//  req     | req_valid / req_ready / req_voltage_mv  | in  | one voltage sample, mV
//  rsp     | rsp_valid / rsp_ready / rsp_*           | out | decivolts, supply off, 4 status
//  csr     | csr_valid / csr_ready / csr_index/data  | in  | register write
//
// One word per cycle unless rsp stalls; a word passes the input register, then
// the result register. The only work between them is one 16x17 multiply for the
// divide-by-100, 16-bit compares for zero and supply off, two compares per channel.
// Reset (synchronous, high) empties both registers, sets every channel to invalid,
// selects the 12 V tables and loads the default supply-off threshold.
// A stalled result holds; the input register keeps taking words as long as the
// result register drains or is empty. csr writes are taken every cycle.
module supply_voltage_window_classifier (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic [svwc_pkg::VOLT_WIDTH-1:0]         req_voltage_mv,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic [svwc_pkg::DECI_WIDTH-1:0]         rsp_voltage_decivolts,
   output logic                                    rsp_supply_off,
   output svwc_pkg::status_type                    rsp_function_status,
   output svwc_pkg::status_type                    rsp_network_status,
   output svwc_pkg::status_type                    rsp_diagnostic_status,
   output svwc_pkg::status_type                    rsp_power_control_status,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [svwc_pkg::CSR_IDX_WIDTH-1:0]      csr_index,
   input  logic [svwc_pkg::VOLT_WIDTH-1:0]         csr_data
);
   import svwc_pkg::*;

   // Configuration registers
   system_type              sys_ff;
   logic [VOLT_WIDTH-1:0]   threshold_ff;

   // Input register
   logic                    in_valid_ff;
   logic [VOLT_WIDTH-1:0]   volt_ff;

   // Channel state
   status_type              status_ff [CHANNELS];
   status_type              status_in [CHANNELS];
   status_type              report_in [REPORTED];

   // Result register
   logic                    out_valid_ff;
   logic [DECI_WIDTH-1:0]   deci_ff;
   logic                    off_ff;
   status_type              report_ff [REPORTED];

   logic                    advance;
   logic                    zero_sample;
   logic [PROD_WIDTH-1:0]   prod;
   logic [DECI_WIDTH-1:0]   deci_in;
   logic                    off_in;

   // Input word moves to the result register when that one is free or draining.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;

   // Divide by 100 via reciprocal multiply; exact over the full 16-bit range.
   assign prod        = PROD_WIDTH'(volt_ff) * PROD_WIDTH'(DECI_RECIP);
   assign deci_in     = prod[DECI_SHIFT +: DECI_WIDTH];
   assign off_in      = volt_ff < threshold_ff;
   assign zero_sample = volt_ff == '0;

   // Every channel is classified in parallel against its own window row.
   for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
      assign status_in[c] = zero_sample ? STATUS_INVALID
                          : classify(status_ff[c], volt_ff, window_of(sys_ff, 2'(c % 4)));
   end

   // Channels that do not exist report invalid; extra channels are not reported.
   for (genvar k = 0; k < REPORTED; k++) begin : g_report
      if (k < CHANNELS) begin : g_live
         assign report_in[k] = status_in[k];
      end else begin : g_none
         assign report_in[k] = STATUS_INVALID;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sys_ff       <= SYSTEM_12V;
         threshold_ff <= OFF_THRESHOLD_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SYSTEM_TYPE:   sys_ff       <= system_type'(csr_data[0]);
            CSR_OFF_THRESHOLD: threshold_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         volt_ff <= req_voltage_mv;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            status_ff[c] <= STATUS_INVALID;
         end
      end else if (advance) begin
         for (int c = 0; c < CHANNELS; c++) begin
            status_ff[c] <= status_in[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
      if (advance) begin
         deci_ff <= deci_in;
         off_ff  <= off_in;
         for (int k = 0; k < REPORTED; k++) begin
            report_ff[k] <= report_in[k];
         end
      end
   end

   assign rsp_valid                = out_valid_ff;
   assign rsp_voltage_decivolts    = deci_ff;
   assign rsp_supply_off           = off_ff;
   assign rsp_function_status      = report_ff[0];
   assign rsp_network_status       = report_ff[1];
   assign rsp_diagnostic_status    = report_ff[2];
   assign rsp_power_control_status = report_ff[3];

   // A zero sample leaves every reported channel invalid.
   a_zero_invalid: assert property (@(posedge clock) disable iff (reset)
      advance && zero_sample |=> rsp_function_status == STATUS_INVALID
         && rsp_network_status == STATUS_INVALID
         && rsp_diagnostic_status == STATUS_INVALID
         && rsp_power_control_status == STATUS_INVALID)
      else $error("zero sample did not invalidate channels");

   // A nonzero sample always yields a real status on channel 0.
   a_nonzero_valid: assert property (@(posedge clock) disable iff (reset)
      advance && !zero_sample |=> rsp_function_status != STATUS_INVALID)
      else $error("nonzero sample left channel 0 invalid");

   // Decivolts times 100 never exceeds the sample and misses it by less than 100.
   a_deci_range: assert property (@(posedge clock) disable iff (reset)
      advance |=> (17'(rsp_voltage_decivolts) * 17'd100 <= 17'($past(volt_ff)))
         && (17'(rsp_voltage_decivolts) * 17'd100 + 17'd100 > 17'($past(volt_ff))))
      else $error("divide by 100 out of range");

   // Input side only back-pressures when both registers are full and stalled.
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> in_valid_ff && out_valid_ff && !rsp_ready)
      else $error("input stalled without cause");

endmodule
